FILE: design/pfa_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Shared types, codes and constants for the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // Fixed field widths and the page size.
    localparam int ADDR_W             = 32;
    localparam int CNT_W              = 13;
    localparam int PAGE_SHIFT         = 12;
    localparam int PAGE_NUM_W         = ADDR_W + 1 - PAGE_SHIFT;
    localparam int DEFAULT_POOL_PAGES = 4096;

    // Page flag encodings.
    localparam logic [2:0] FLAG_NONE     = 3'b000;
    localparam logic [2:0] FLAG_AVAIL    = 3'b001;
    localparam logic [2:0] FLAG_USED     = 3'b010;
    localparam logic [2:0] FLAG_DISABLED = 3'b100;

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_RESERVE = 2'd1,
        CMD_ALLOC   = 2'd2,
        CMD_FREE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BADARG = 2'd1,
        STAT_OOM    = 2'd2,
        STAT_NORUN  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_MARK,
        ST_FINISH
    } state_t;

    // Decoded command: a clamped page range [first_page, end_page).
    typedef struct packed {
        cmd_t                  cmd;
        logic [PAGE_NUM_W-1:0] first_page;
        logic [PAGE_NUM_W-1:0] end_page;
        logic [CNT_W-1:0]      count;
        logic                  bad_arg;
    } pfa_range_t;

    // One result word.
    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] alloc_addr;
        logic [CNT_W-1:0]  pages_in_use;
        logic [CNT_W-1:0]  pages_available;
    } pfa_result_t;

endpackage

FILE: design/pfa_flag_ram.sv
// ----------------------------------------------------------------------------
// Page flag memory
// Simple dual-port synchronous RAM holding three flag bits per page, with a
// registered read port.
// ----------------------------------------------------------------------------
module pfa_flag_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [2:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [2:0]    wr_data
);

    logic [2:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/pfa_cmd_decode.sv
// ----------------------------------------------------------------------------
// Command decoder
// Turns the byte addresses and count of a command word into a page range
// clamped to the pool, and flags the argument errors.
// ----------------------------------------------------------------------------
module pfa_cmd_decode #(
    parameter int POOL_PAGES = pfa_pkg::DEFAULT_POOL_PAGES
) (
    input  logic [1:0]                command,
    input  logic [pfa_pkg::ADDR_W-1:0] start_addr,
    input  logic [pfa_pkg::ADDR_W-1:0] end_addr,
    input  logic [pfa_pkg::CNT_W-1:0]  page_count,
    output pfa_pkg::pfa_range_t       range
);

    import pfa_pkg::*;

    localparam logic [PAGE_NUM_W-1:0] POOL_N   = PAGE_NUM_W'(POOL_PAGES);
    localparam logic [ADDR_W:0]       PAGE_RND = (ADDR_W + 1)'((1 << PAGE_SHIFT) - 1);

    logic [ADDR_W:0]       start_up;
    logic [ADDR_W:0]       end_up;
    logic [ADDR_W:0]       span_up;
    logic [PAGE_NUM_W-1:0] start_pg;
    logic [PAGE_NUM_W-1:0] first_raw;
    logic [PAGE_NUM_W-1:0] end_raw;
    cmd_t                  cmd;

    function automatic logic [PAGE_NUM_W-1:0] clamp_pool(input logic [PAGE_NUM_W-1:0] pg);
        clamp_pool = (pg > POOL_N) ? POOL_N : pg;
    endfunction

    // Rounded-up addresses for the add range and the reserve span.
    assign cmd      = cmd_t'(command);
    assign start_up = {1'b0, start_addr} + PAGE_RND;
    assign end_up   = {1'b0, end_addr} + PAGE_RND;
    assign span_up  = ({1'b0, end_addr} - {1'b0, start_addr}) + PAGE_RND;
    assign start_pg = PAGE_NUM_W'(start_addr[ADDR_W-1:PAGE_SHIFT]);

    // Unclamped page range for each command.
    always_comb
    begin
        first_raw = start_pg;
        end_raw   = start_pg;
        case (cmd)
            CMD_ADD:
            begin
                first_raw = start_up[ADDR_W:PAGE_SHIFT];
                end_raw   = end_up[ADDR_W:PAGE_SHIFT];
            end
            CMD_RESERVE:
            begin
                // An end below the start gives an empty range.
                if (end_addr >= start_addr)
                begin
                    end_raw = start_pg + span_up[ADDR_W:PAGE_SHIFT];
                end
            end
            CMD_FREE:
            begin
                end_raw = start_pg + PAGE_NUM_W'(page_count);
            end
            default:
            begin
                first_raw = start_pg;
                end_raw   = start_pg;
            end
        endcase
    end

    // Clamp to the pool and flag argument errors.
    always_comb
    begin
        range.cmd        = cmd;
        range.first_page = clamp_pool(first_raw);
        range.end_page   = clamp_pool(end_raw);
        range.count      = page_count;
        range.bad_arg    = ((cmd == CMD_ALLOC) && (page_count == '0)) ||
                           ((cmd == CMD_FREE) && (start_addr == '0));
    end

endmodule

FILE: design/pfa_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Clears the flag memory after reset, then walks page ranges one page per
// cycle through a read-modify-write pipeline on the flag memory, keeps the
// page counters and produces one result word per command.
// ----------------------------------------------------------------------------
module pfa_ctrl #(
    parameter int POOL_PAGES = pfa_pkg::DEFAULT_POOL_PAGES,
    parameter int PW         = $clog2(POOL_PAGES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pfa_pkg::pfa_range_t  range,
    input  logic                 out_free,
    output logic                 res_valid,
    output pfa_pkg::pfa_result_t result,
    output logic                 rd_en,
    output logic [PW-1:0]        rd_addr,
    input  logic [2:0]           rd_data,
    output logic                 wr_en,
    output logic [PW-1:0]        wr_addr,
    output logic [2:0]           wr_data
);

    import pfa_pkg::*;

    localparam int            CW     = $clog2(POOL_PAGES + 1);
    localparam int            CMPW   = ((CW > CNT_W) ? CW : CNT_W) + 1;
    localparam logic [PW:0]   POOL_C = (PW + 1)'(POOL_PAGES);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [PW:0]         cur_reg, cur_next;
    logic [PW:0]         end_reg, end_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic [PW-1:0]       first_reg, first_next;
    logic                s1_vld_reg;
    logic [PW-1:0]       s1_page_reg, s1_page_next;
    logic [CW-1:0]       avail_reg, avail_next;
    logic [CW-1:0]       used_reg, used_next;
    logic [PW-1:0]       lgp_reg, lgp_next;
    status_t             status_reg, status_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;

    logic                accept;
    logic                oom;
    logic                early;
    logic                cur_lt_end;
    logic                clr_busy;
    logic                hit;
    logic [CNT_W-1:0]    run_inc;
    logic [PW-1:0]       first_sel;
    logic [PAGE_NUM_W-1:0] mark_end;

    // Handshake and early-exit conditions.
    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign oom        = (CMPW'(used_reg) + CMPW'(range.count)) > CMPW'(avail_reg);
    assign early      = range.bad_arg || ((range.cmd == CMD_ALLOC) && oom);
    assign cur_lt_end = (cur_reg < end_reg);
    assign clr_busy   = (cur_reg < POOL_C);

    // First-fit run tracking on the word returned by the memory.
    assign run_inc   = run_reg + CNT_W'(1);
    assign first_sel = (run_reg == '0) ? s1_page_reg : first_reg;
    assign hit       = (state_reg == ST_WALK) && s1_vld_reg && (cmd_reg == CMD_ALLOC) &&
                       rd_data[0] && (run_inc >= cnt_reg);
    assign mark_end  = PAGE_NUM_W'(first_sel) + PAGE_NUM_W'(cnt_reg);

    // Memory read side: one page issued per cycle while walking.
    assign rd_en   = (state_reg == ST_WALK) && cur_lt_end && !hit;
    assign rd_addr = cur_reg[PW-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (!clr_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = early ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    state_next = ST_MARK;
                end
                else if (!cur_lt_end && !s1_vld_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MARK:
            begin
                if (!cur_lt_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: memory writes and the result word.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = s1_page_reg;
        wr_data = FLAG_NONE;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = clr_busy;
                wr_addr = cur_reg[PW-1:0];
                wr_data = FLAG_NONE;
            end
            ST_WALK:
            begin
                if (s1_vld_reg)
                begin
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            wr_en   = (rd_data == FLAG_NONE);
                            wr_data = FLAG_AVAIL;
                        end
                        CMD_RESERVE:
                        begin
                            wr_en   = 1'b1;
                            wr_data = FLAG_DISABLED;
                        end
                        CMD_FREE:
                        begin
                            wr_en   = rd_data[1];
                            wr_data = (rd_data | FLAG_AVAIL) & ~FLAG_USED;
                        end
                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
            end
            ST_MARK:
            begin
                wr_en   = cur_lt_end;
                wr_addr = cur_reg[PW-1:0];
                wr_data = FLAG_USED;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign res_valid              = (state_reg == ST_FINISH) && out_free;
    assign result.status          = status_reg;
    assign result.alloc_addr      = addr_reg;
    assign result.pages_in_use    = CNT_W'(used_reg);
    assign result.pages_available = CNT_W'(avail_reg);

    // Datapath next values.
    always_comb
    begin
        cmd_next     = cmd_reg;
        cur_next     = cur_reg;
        end_next     = end_reg;
        cnt_next     = cnt_reg;
        run_next     = run_reg;
        first_next   = first_reg;
        s1_page_next = s1_page_reg;
        avail_next   = avail_reg;
        used_next    = used_reg;
        lgp_next     = lgp_reg;
        status_next  = status_reg;
        addr_next    = addr_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_busy)
                begin
                    cur_next = cur_reg + (PW + 1)'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = range.cmd;
                    cnt_next  = range.count;
                    run_next  = '0;
                    addr_next = '0;
                    if (range.cmd == CMD_ALLOC)
                    begin
                        cur_next = (PW + 1)'(lgp_reg);
                        end_next = POOL_C;
                    end
                    else
                    begin
                        cur_next = range.first_page[PW:0];
                        end_next = range.end_page[PW:0];
                    end
                    if (range.bad_arg)
                    begin
                        status_next = STAT_BADARG;
                    end
                    else if ((range.cmd == CMD_ALLOC) && oom)
                    begin
                        status_next = STAT_OOM;
                    end
                    else if (range.cmd == CMD_ALLOC)
                    begin
                        // Replaced by an ok status when a run is found.
                        status_next = STAT_NORUN;
                    end
                    else
                    begin
                        status_next = STAT_OK;
                    end
                end
            end
            ST_WALK:
            begin
                if (rd_en)
                begin
                    cur_next     = cur_reg + (PW + 1)'(1);
                    s1_page_next = cur_reg[PW-1:0];
                end
                if (s1_vld_reg)
                begin
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (rd_data == FLAG_NONE)
                            begin
                                avail_next = avail_reg + CW'(1);
                                // Zero in the lowest good page counts as unset.
                                if ((lgp_reg == '0) || (lgp_reg > s1_page_reg))
                                begin
                                    lgp_next = s1_page_reg;
                                end
                            end
                        end
                        CMD_RESERVE:
                        begin
                            if (rd_data[0] && (avail_reg != '0))
                            begin
                                avail_next = avail_reg - CW'(1);
                            end
                        end
                        CMD_FREE:
                        begin
                            if (rd_data[1] && (used_reg != '0))
                            begin
                                used_next = used_reg - CW'(1);
                            end
                        end
                        CMD_ALLOC:
                        begin
                            if (!rd_data[0])
                            begin
                                run_next = '0;
                            end
                            else
                            begin
                                run_next   = run_inc;
                                first_next = first_sel;
                            end
                            if (hit)
                            begin
                                cur_next    = (PW + 1)'(first_sel);
                                end_next    = mark_end[PW:0];
                                used_next   = CW'(CMPW'(used_reg) + CMPW'(cnt_reg));
                                status_next = STAT_OK;
                                addr_next   = ADDR_W'(first_sel) << PAGE_SHIFT;
                            end
                        end
                        default:
                        begin
                            run_next = run_reg;
                        end
                    endcase
                end
            end
            ST_MARK:
            begin
                if (cur_lt_end)
                begin
                    cur_next = cur_reg + (PW + 1)'(1);
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            cur_reg    <= '0;
            end_reg    <= '0;
            s1_vld_reg <= 1'b0;
            avail_reg  <= '0;
            used_reg   <= '0;
            lgp_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            end_reg    <= end_next;
            s1_vld_reg <= rd_en;
            avail_reg  <= avail_next;
            used_reg   <= used_next;
            lgp_reg    <= lgp_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        cnt_reg     <= cnt_next;
        run_reg     <= run_next;
        first_reg   <= first_next;
        s1_page_reg <= s1_page_next;
        status_reg  <= status_next;
        addr_reg    <= addr_next;
    end

endmodule

FILE: design/page_frame_allocator.sv
// ----------------------------------------------------------------------------
// Page frame allocator
// First-fit contiguous allocator over 4 KiB page flags held in one memory.
// ----------------------------------------------------------------------------
// Each command word gives exactly one result word. After reset the block
// clears the flag memory before it accepts the first command. The flags
// are walked one page per cycle through a pipelined read-modify-write on
// the flag memory. Add, reserve and free walk the pages in their range
// (clamped to the pool); allocate scans from the lowest good page until a
// run is found, then marks the page_count pages of the run; argument and
// capacity errors skip the walk and go straight to the result word. The
// next command is taken while a finished result word still waits in the
// output register.
module page_frame_allocator #(
    parameter int POOL_PAGES = pfa_pkg::DEFAULT_POOL_PAGES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic [pfa_pkg::ADDR_W-1:0] start_addr,
    input  logic [pfa_pkg::ADDR_W-1:0] end_addr,
    input  logic [pfa_pkg::CNT_W-1:0]  page_count,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [pfa_pkg::ADDR_W-1:0] alloc_addr,
    output logic [pfa_pkg::CNT_W-1:0]  pages_in_use,
    output logic [pfa_pkg::CNT_W-1:0]  pages_available
);

    import pfa_pkg::*;

    localparam int PW = $clog2(POOL_PAGES);

    pfa_range_t    range;
    pfa_result_t   result;
    pfa_result_t   res_reg;
    logic          out_vld_reg;
    logic          out_free;
    logic          res_valid;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic [2:0]    rd_data;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [2:0]    wr_data;

    pfa_cmd_decode #(
        .POOL_PAGES (POOL_PAGES)
    ) u_decode (
        .command    (command),
        .start_addr (start_addr),
        .end_addr   (end_addr),
        .page_count (page_count),
        .range      (range)
    );

    pfa_ctrl #(
        .POOL_PAGES (POOL_PAGES),
        .PW         (PW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .range     (range),
        .out_free  (out_free),
        .res_valid (res_valid),
        .result    (result),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    pfa_flag_ram #(
        .DEPTH (POOL_PAGES),
        .AW    (PW)
    ) u_flags (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Output register: free when empty or being taken this cycle.
    assign out_free = !out_vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= result;
        end
    end

    // Result word onto the ports.
    assign out_valid       = out_vld_reg;
    assign status          = res_reg.status;
    assign alloc_addr      = res_reg.alloc_addr;
    assign pages_in_use    = res_reg.pages_in_use;
    assign pages_available = res_reg.pages_available;

endmodule
